/* design/rgb_pkg.sv */
// Shared constants, codes and types for the rotated glyph blitter.
package rgb_pkg;

    localparam int PANEL_WIDTH  = 200;
    localparam int PANEL_HEIGHT = 200;
    localparam int ROW_BYTES    = 25;
    localparam int GLYPH_BYTES  = 32768;
    localparam int FONT_SLOTS   = 4;

    localparam int FRAME_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int FB_AW        = $clog2(FRAME_BYTES);
    localparam int GLYPH_AW     = $clog2(GLYPH_BYTES);
    localparam int DESC_DEPTH   = 4;     // font_select is two bits wide
    localparam int CW           = 13;    // signed working width of coordinates
    localparam int IDX_W        = 24;    // frame index arithmetic width
    localparam int END_W        = 20;    // glyph span end arithmetic width

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] WHITE_BYTE = 8'hFF;
    localparam logic [1:0] ROT_RESET  = 2'd3;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_DOT   = 3'd1,
        OP_CHAR  = 3'd2,
        OP_GLYPH = 3'd3,
        OP_DESC  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DOT_RD,
        S_DOT_WR,
        S_RD_WAIT,
        S_CH_SIZE,
        S_CH_PROD,
        S_CH_CHECK,
        S_CH_GRD,
        S_CH_GWAIT,
        S_CH_BIT,
        S_CH_NEXT,
        S_FIN
    } state_t;

endpackage

/* design/rgb_ram.sv */
// Generic simple dual-port RAM with registered read.
module rgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/rotated_glyph_blitter_1bpp_top.sv */
// Top level of the rotated 1bpp glyph blitter: sequencer, dot unit and memories.
//
// Usage
//   Input channel: in_valid / in_stall carry one operation per beat (clear, dot,
//   draw character, glyph byte write, descriptor write, frame byte read).
//   Output channel: out_valid / out_stall return exactly one result beat per
//   input beat (read_byte, advance, error), in order.
//   Config: cfg_write_en writes the rotation register from cfg_write_data;
//   the user does so only while idle (not enforced). Rotation resets to 270 degrees.
// Sequencing
//   One item at a time; the next beat is taken once the result sits in the
//   output register. A character first sizes its glyph and forms the glyph
//   offset, then fetches each glyph byte and examines each of its bits in
//   turn; a set bit that lands on the panel is a read-modify-write on the
//   single frame buffer port pair, and a clipped set bit writes nothing.
// Reset
//   After reset the frame buffer is swept to white, one byte a cycle, over all
//   FRAME_BYTES (5000) bytes with in_stall high; config writes still land.
// Stall
//   A stalled result holds in the output register; a finished item waits in
//   its final state until that register frees up.
module rotated_glyph_blitter_1bpp_top
    import rgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          operation,
    input  logic signed [10:0]  x_pos,
    input  logic signed [10:0]  y_pos,
    input  logic                color,
    input  logic [7:0]          char_code,
    input  logic [1:0]          font_select,
    input  logic [14:0]         mem_address,
    input  logic [29:0]         write_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          read_byte,
    output logic [7:0]          advance,
    output logic                error,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_write_data
);

    // ---------------- state ----------------
    state_t                 state_reg, state_next;
    logic [1:0]             rot_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [FB_AW-1:0]       clr_cnt_reg, clr_cnt_next;

    logic [7:0]             read_byte_reg, read_byte_next;
    logic [7:0]             advance_reg, advance_next;
    logic                   error_reg, error_next;
    logic [7:0]             res_rd_reg, res_rd_next;
    logic [7:0]             res_adv_reg, res_adv_next;
    logic                   res_err_reg, res_err_next;

    logic signed [CW-1:0]   dot_x_reg, dot_x_next;
    logic signed [CW-1:0]   dot_y_reg, dot_y_next;
    logic                   dot_white_reg, dot_white_next;
    logic                   ch_mode_reg, ch_mode_next;

    logic signed [CW-1:0]   x0_reg, x0_next;
    logic signed [CW-1:0]   y0_reg, y0_next;
    logic [7:0]             gi_reg, gi_next;
    logic [14:0]            base_reg, base_next;
    logic                   vert_reg, vert_next;
    logic [6:0]             h_reg, h_next;
    logic [6:0]             w_reg, w_next;
    logic [10:0]            size_reg, size_next;
    logic [18:0]            prod_reg, prod_next;
    logic [GLYPH_AW-1:0]    g_addr_reg, g_addr_next;
    logic [7:0]             g_byte_reg, g_byte_next;
    logic [6:0]             row_reg, row_next;
    logic [6:0]             col_reg, col_next;
    logic [2:0]             bit_reg, bit_next;

    logic [29:0]            desc_reg [DESC_DEPTH];

    // ---------------- memories ----------------
    logic                   fb_we;
    logic [FB_AW-1:0]       fb_waddr, fb_raddr;
    logic [7:0]             fb_wdata, fb_rdata;
    logic                   gm_we;
    logic [7:0]             gm_rdata;

    rgb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    rgb_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_glyph (
        .clk   (clk),
        .we    (gm_we),
        .waddr (mem_address[GLYPH_AW-1:0]),
        .wdata (write_data[7:0]),
        .raddr (g_addr_reg),
        .rdata (gm_rdata)
    );

    logic in_acc;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    logic glyph_addr_ok;
    assign glyph_addr_ok = {5'd0, mem_address} < END_W'(GLYPH_BYTES);
    assign gm_we = in_acc && (op_t'(operation) == OP_GLYPH) && glyph_addr_ok;

    // ---------------- dot unit: rotate, clip, address ----------------
    logic signed [CW-1:0]   px, py;
    logic                   dot_hit;
    logic [CW-5:0]          dot_col;
    logic [IDX_W-1:0]       dot_idx_full;
    logic [FB_AW-1:0]       dot_idx;
    logic [7:0]             dot_mask;

    always_comb
    begin
        case (rot_t'(rot_reg))
            ROT_270:
            begin
                px = dot_y_reg;
                py = $signed(CW'(PANEL_WIDTH - 1)) - dot_x_reg;
            end
            ROT_180:
            begin
                px = $signed(CW'(PANEL_WIDTH - 1)) - dot_x_reg;
                py = $signed(CW'(PANEL_HEIGHT - 1)) - dot_y_reg;
            end
            ROT_90:
            begin
                px = $signed(CW'(PANEL_HEIGHT - 1)) - dot_y_reg;
                py = dot_x_reg;
            end
            default:
            begin
                px = dot_x_reg;
                py = dot_y_reg;
            end
        endcase
        dot_col      = px[CW-2:3];
        dot_hit      = (px >= 0) && (py >= 0)
                    && (px < $signed(CW'(PANEL_WIDTH)))
                    && (py < $signed(CW'(PANEL_HEIGHT)))
                    && ({1'b0, dot_col} < (CW-3)'(ROW_BYTES));
        dot_idx_full = IDX_W'(py[CW-2:0]) * IDX_W'(ROW_BYTES) + IDX_W'(dot_col);
        dot_idx      = dot_idx_full[FB_AW-1:0];
        dot_mask     = 8'h80 >> px[2:0];
    end

    // ---------------- character loop limits ----------------
    logic [7:0]  w_plus7;
    logic [4:0]  wb;
    logic [3:0]  v_rows, n_bits;
    logic [6:0]  n_cols, n_rows;
    logic        ch_empty;
    logic [END_W-1:0] g_start, g_end;
    logic        bit_set;
    logic signed [CW-1:0] off_x, off_y;
    logic [29:0] desc_sel;

    always_comb
    begin
        w_plus7  = {1'b0, w_reg} + 8'd7;
        wb       = w_plus7[7:3];
        v_rows   = (h_reg > 7'd8) ? 4'd8 : h_reg[3:0];
        n_bits   = vert_reg ? v_rows : 4'd8;
        n_cols   = vert_reg ? w_reg : {2'b0, wb};
        n_rows   = vert_reg ? 7'd1 : h_reg;
        ch_empty = vert_reg ? ((w_reg == 7'd0) || (h_reg == 7'd0)) : (size_reg == 11'd0);
        g_start  = END_W'(base_reg) + END_W'(prod_reg);
        g_end    = g_start + END_W'(size_reg);
        bit_set  = vert_reg ? g_byte_reg[bit_reg] : g_byte_reg[3'd7 - bit_reg];
        off_x    = vert_reg ? $signed(CW'(col_reg))
                            : $signed(CW'({col_reg, 3'b000}) + CW'(bit_reg));
        off_y    = vert_reg ? $signed(CW'(bit_reg)) : $signed(CW'(row_reg));
        desc_sel = desc_reg[font_select];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        clr_cnt_next   = clr_cnt_reg;
        read_byte_next = read_byte_reg;
        advance_next   = advance_reg;
        error_next     = error_reg;
        res_rd_next    = res_rd_reg;
        res_adv_next   = res_adv_reg;
        res_err_next   = res_err_reg;
        dot_x_next     = dot_x_reg;
        dot_y_next     = dot_y_reg;
        dot_white_next = dot_white_reg;
        ch_mode_next   = ch_mode_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        gi_next        = gi_reg;
        base_next      = base_reg;
        vert_next      = vert_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        size_next      = size_reg;
        prod_next      = prod_reg;
        g_addr_next    = g_addr_reg;
        g_byte_next    = g_byte_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        bit_next       = bit_reg;
        fb_we          = 1'b0;
        fb_waddr       = dot_idx;
        fb_wdata       = WHITE_BYTE;
        fb_raddr       = dot_idx;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                fb_we    = 1'b1;
                fb_waddr = clr_cnt_reg;
                fb_wdata = WHITE_BYTE;
                if (clr_cnt_reg == FB_AW'(FRAME_BYTES - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = (state_reg == S_INIT) ? S_IDLE : S_FIN;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                fb_raddr = mem_address[FB_AW-1:0];
                if (in_acc)
                begin
                    res_rd_next  = 8'd0;
                    res_adv_next = 8'd0;
                    res_err_next = 1'b0;
                    ch_mode_next = 1'b0;
                    state_next   = S_FIN;
                    case (op_t'(operation))
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_DOT:
                        begin
                            dot_x_next     = {{(CW-11){x_pos[10]}}, x_pos};
                            dot_y_next     = {{(CW-11){y_pos[10]}}, y_pos};
                            dot_white_next = color;
                            state_next     = S_DOT_RD;
                        end
                        OP_CHAR:
                        begin
                            x0_next        = {{(CW-11){x_pos[10]}}, x_pos};
                            y0_next        = {{(CW-11){y_pos[10]}}, y_pos};
                            gi_next        = char_code - FIRST_CODE;
                            base_next      = desc_sel[29:15];
                            vert_next      = desc_sel[14];
                            h_next         = desc_sel[13:7];
                            w_next         = desc_sel[6:0];
                            dot_white_next = 1'b0;
                            ch_mode_next   = 1'b1;
                            if ((char_code < FIRST_CODE)
                                || ({1'b0, font_select} >= 3'(FONT_SLOTS)))
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_CH_SIZE;
                            end
                        end
                        OP_READ:
                        begin
                            if (mem_address < 15'(FRAME_BYTES))
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default: ;   // glyph and descriptor writes land directly
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                res_rd_next = fb_rdata;
                state_next  = S_FIN;
            end
            S_DOT_RD:
            begin
                if (dot_hit)
                begin
                    state_next = S_DOT_WR;
                end
                else
                begin
                    state_next = ch_mode_reg ? S_CH_NEXT : S_FIN;
                end
            end
            S_DOT_WR:
            begin
                fb_we      = 1'b1;
                fb_wdata   = dot_white_reg ? (fb_rdata | dot_mask) : (fb_rdata & ~dot_mask);
                state_next = ch_mode_reg ? S_CH_NEXT : S_FIN;
            end
            S_CH_SIZE:
            begin
                size_next  = vert_reg ? {4'd0, w_reg} : 11'(wb * h_reg);
                state_next = S_CH_PROD;
            end
            S_CH_PROD:
            begin
                prod_next  = 19'(gi_reg * size_reg);
                state_next = S_CH_CHECK;
            end
            S_CH_CHECK:
            begin
                row_next    = '0;
                col_next    = '0;
                bit_next    = '0;
                g_addr_next = g_start[GLYPH_AW-1:0];
                if (ch_empty)
                begin
                    res_adv_next = vert_reg ? ({1'b0, w_reg} + 8'd1) : {1'b0, w_reg};
                    state_next   = S_FIN;
                end
                else if (g_end > END_W'(GLYPH_BYTES))
                begin
                    res_err_next = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    res_adv_next = vert_reg ? ({1'b0, w_reg} + 8'd1) : {1'b0, w_reg};
                    state_next   = S_CH_GRD;
                end
            end
            S_CH_GRD:   state_next = S_CH_GWAIT;
            S_CH_GWAIT:
            begin
                g_byte_next = gm_rdata;
                state_next  = S_CH_BIT;
            end
            S_CH_BIT:
            begin
                dot_x_next = x0_reg + off_x;
                dot_y_next = y0_reg + off_y;
                state_next = bit_set ? S_DOT_RD : S_CH_NEXT;
            end
            S_CH_NEXT:
            begin
                if (({1'b0, bit_reg} + 4'd1) < n_bits)
                begin
                    bit_next   = bit_reg + 1'b1;
                    state_next = S_CH_BIT;
                end
                else
                begin
                    bit_next    = '0;
                    g_addr_next = g_addr_reg + 1'b1;
                    if (({1'b0, col_reg} + 8'd1) < {1'b0, n_cols})
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_CH_GRD;
                    end
                    else if (({1'b0, row_reg} + 8'd1) < {1'b0, n_rows})
                    begin
                        col_next   = '0;
                        row_next   = row_reg + 1'b1;
                        state_next = S_CH_GRD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    read_byte_next = res_rd_reg;
                    advance_next   = res_adv_reg;
                    error_next     = res_err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            rot_reg       <= ROT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_write_en)
            begin
                rot_reg <= cfg_write_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        read_byte_reg <= read_byte_next;
        advance_reg   <= advance_next;
        error_reg     <= error_next;
        res_rd_reg    <= res_rd_next;
        res_adv_reg   <= res_adv_next;
        res_err_reg   <= res_err_next;
        dot_x_reg     <= dot_x_next;
        dot_y_reg     <= dot_y_next;
        dot_white_reg <= dot_white_next;
        ch_mode_reg   <= ch_mode_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        gi_reg        <= gi_next;
        base_reg      <= base_next;
        vert_reg      <= vert_next;
        h_reg         <= h_next;
        w_reg         <= w_next;
        size_reg      <= size_next;
        prod_reg      <= prod_next;
        g_addr_reg    <= g_addr_next;
        g_byte_reg    <= g_byte_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        bit_reg       <= bit_next;
        if (in_acc && (op_t'(operation) == OP_DESC)
            && ({1'b0, font_select} < 3'(FONT_SLOTS)))
        begin
            desc_reg[font_select] <= write_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_byte = read_byte_reg;
    assign advance   = advance_reg;
    assign error     = error_reg;

`ifndef SYNTHESIS
    // a frame write-back always follows the read of the same dot
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOT_WR) |-> ($past(state_reg) == S_DOT_RD))
        else $error("frame write-back without preceding read");

    // a pending result is never dropped while the receiver stalls
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    // no input is taken during the power-up clearing sweep
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> in_stall)
        else $error("input accepted during frame clearing");
`endif

endmodule
